// ===== sv/dahq_pkg.sv =====
// ----------------------------------------------------------------------------
// dahq_pkg
// Shared widths, defaults and codes for the d-ary max-heap priority queue.
// ----------------------------------------------------------------------------
package dahq_pkg;
  localparam int DefCapacity  = 256;
  localparam int DefMaxArity  = 8;
  localparam int KeyWidth     = 32;
  localparam int ArityWidth   = 4;
  localparam int StatusWidth  = 2;

  localparam logic [StatusWidth-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_FULL  = 2'd2;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [ArityWidth-1:0] ARITY_RESET = 4'd2;
  localparam logic [1:0] REG_ARITY = 2'd0;
endpackage

// ===== sv/d_ary_max_heap_queue.sv =====
// ----------------------------------------------------------------------------
// d_ary_max_heap_queue
// Max-priority queue held as a d-ary heap in one synchronous memory.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An insert starts from a hole at the end of
// the heap and climbs: each level has three steps, forming the parent index,
// reading the parent, and comparing and moving it down, until the new key is
// written in place. An extract reads the root and the last entry, then
// descends: each child is read and then compared, one at a time through the
// single memory read port, and each level ends in a swap step. The memory
// read port sets this pace. The result sits in an output register; the next
// item is taken once it has been handed over. The arity register is read at
// the start of each item.
// Output tdata holds max_key [31:0], status [33:32], count [42:34], padded to
// 48 bits. Input tdata holds the key; tuser holds the operation.
module d_ary_max_heap_queue
  import dahq_pkg::*;
#(
  parameter int CAPACITY  = DefCapacity,
  parameter int MAX_ARITY = DefMaxArity
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [KeyWidth-1:0]    s_tdata,   // key [31:0]
  input  logic                   s_tuser,   // operation [0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [47:0]            m_tdata,   // max_key, status, count, zero pad
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = $clog2(MAX_ARITY + 1);
  // Node indexes of up to CAPACITY*MAX_ARITY+MAX_ARITY must not wrap.
  localparam int PW = AW + DW + 1;
  // Reciprocal precision: exact quotients for any index below 2**PW and any
  // arity up to 16.
  localparam int RS = PW + 4;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UPRD  = 4'd1;
  localparam logic [3:0] S_UPCMP = 4'd2;
  localparam logic [3:0] S_EXRT  = 4'd3;
  localparam logic [3:0] S_EXLST = 4'd4;
  localparam logic [3:0] S_EXSET = 4'd5;
  localparam logic [3:0] S_DNRD  = 4'd6;
  localparam logic [3:0] S_DNCMP = 4'd7;
  localparam logic [3:0] S_DNSWP = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;

  logic signed [KeyWidth-1:0] mem [CAPACITY];
  logic signed [KeyWidth-1:0] rdata;
  logic [AW-1:0]              raddr, waddr;
  logic                       ren, wen;
  logic signed [KeyWidth-1:0] wdata;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  logic [3:0]            state;
  logic [ArityWidth-1:0] arity;
  logic [DW-1:0]         d;
  logic [CW-1:0]         entry_count;
  logic [PW-1:0]         pos, up, chd, best;
  logic [DW-1:0]         cidx;
  logic signed [KeyWidth-1:0] key, best_key;
  logic [PW-1:0]         dividend;
  logic [RS-1:0]         recip;
  logic [PW+RS-1:0]      prod;
  logic [KeyWidth-1:0]   out_key;
  logic [StatusWidth-1:0] out_status;

  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_ARITY) ? {28'd0, arity} : 32'd0;
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {5'd0, 9'(entry_count), out_status, out_key};

  // Arity clamped to the supported range.
  logic [DW-1:0] d_eff;
  always_comb begin
    if (arity < 4'd2) begin
      d_eff = DW'(2);
    end else if (32'(arity) > MAX_ARITY) begin
      d_eff = DW'(MAX_ARITY);
    end else begin
      d_eff = DW'(arity);
    end
  end

  // Rounded-up reciprocals 2**RS / d, one per arity.
  logic [RS-1:0] recip_tab [MAX_ARITY+1];
  for (genvar g = 0; g <= MAX_ARITY; g++) begin : g_recip
    if (g < 2) begin : g_none
      assign recip_tab[g] = '0;
    end else begin : g_div
      assign recip_tab[g] = RS'(((64'd1 << RS) + 64'(g) - 64'd1) / 64'(g));
    end
  end

  assign prod = (PW+RS)'(dividend) * (PW+RS)'(recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      arity <= ARITY_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_ARITY) begin
      arity <= pwdata[ArityWidth-1:0];
    end
  end

  // Memory port control, driven from the current state.
  always_comb begin
    ren   = 1'b0;
    raddr = pos[AW-1:0];
    wen   = 1'b0;
    waddr = pos[AW-1:0];
    wdata = key;
    case (state)
      S_UPRD: begin
        ren   = 1'b1;
        raddr = up[AW-1:0];
      end
      S_UPCMP: begin
        wen = 1'b1;
        if (pos != '0 && rdata < key) begin
          wdata = rdata;
        end
      end
      S_EXRT: begin
        ren   = 1'b1;
        raddr = '0;
      end
      S_EXLST: begin
        ren   = 1'b1;
        raddr = AW'(entry_count - CW'(1));
      end
      S_DNRD: begin
        ren   = 1'b1;
        raddr = chd[AW-1:0];
      end
      S_DNSWP: begin
        if (best != pos) begin
          wen   = 1'b1;
          wdata = best_key;
        end else begin
          wen = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // The parent index (pos-1)/d is found in the S_DIV state by multiplying with the
  // reciprocal of the arity taken at the start of the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            d     <= d_eff;
            recip <= recip_tab[d_eff];
            if (s_tuser == OP_INSERT) begin
              if (32'(entry_count) >= CAPACITY) begin
                out_key    <= '0;
                out_status <= STATUS_FULL;
                state      <= S_OUT;
              end else begin
                key         <= s_tdata;
                pos         <= PW'(entry_count);
                entry_count <= entry_count + CW'(1);
                out_key     <= '0;
                out_status  <= STATUS_OK;
                if (entry_count == '0) begin
                  state <= S_UPCMP;
                  up    <= '0;
                end else begin
                  dividend <= PW'(entry_count) - PW'(1);
                  state    <= S_DIV;
                end
              end
            end else begin
              if (entry_count == '0) begin
                out_key    <= '0;
                out_status <= STATUS_EMPTY;
                state      <= S_OUT;
              end else begin
                out_status <= STATUS_OK;
                state      <= S_EXRT;
              end
            end
          end
        end
        S_DIV: begin
          up    <= prod[PW+RS-1:RS];
          state <= S_UPRD;
        end
        S_UPRD: begin
          state <= S_UPCMP;
        end
        S_UPCMP: begin
          // pos == 0 reaches here with key written directly.
          if (pos != '0 && rdata < key) begin
            pos <= up;
            if (up == '0) begin
              state <= S_UPCMP;
              // Next pass writes key at the root.
            end else begin
              dividend <= up - PW'(1);
              state    <= S_DIV;
            end
          end else begin
            state <= S_OUT;
          end
        end
        S_EXRT: begin
          state <= S_EXLST;
        end
        S_EXLST: begin
          out_key     <= rdata;
          entry_count <= entry_count - CW'(1);
          state       <= S_EXSET;
        end
        S_EXSET: begin
          key <= rdata;
          pos <= '0;
          if (entry_count == '0) begin
            state <= S_OUT;
          end else begin
            best     <= '0;
            best_key <= rdata;
            chd      <= PW'(1);
            cidx     <= '0;
            state    <= (PW'(1) < PW'(entry_count)) ? S_DNRD : S_DNSWP;
          end
        end
        S_DNRD: begin
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (rdata > best_key) begin
            best     <= chd;
            best_key <= rdata;
          end
          if (cidx + DW'(1) < d && chd + PW'(1) < PW'(entry_count)) begin
            cidx  <= cidx + DW'(1);
            chd   <= chd + PW'(1);
            state <= S_DNRD;
          end else begin
            state <= S_DNSWP;
          end
        end
        S_DNSWP: begin
          // Root key climbs down to best; best's key moved into pos.
          if (best != pos) begin
            pos      <= best;
            best_key <= key;
            chd      <= best * PW'(d) + PW'(1);
            cidx     <= '0;
            if (best * PW'(d) + PW'(1) < PW'(entry_count)) begin
              state <= S_DNRD;
            end else begin
              state <= S_DNSWP;
            end
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== dv/heap_queue_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heap_queue_checker
// Watches the item and result channels and the register port of the d-ary
// max-heap queue, keeps its own heap to predict each result and compares.
// ----------------------------------------------------------------------------
module heap_queue_checker
  import dahq_pkg::*;
#(
  parameter int CAPACITY  = DefCapacity,
  parameter int MAX_ARITY = DefMaxArity
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [KeyWidth-1:0] s_tdata,
  input  logic                s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [47:0]         m_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output int                  fail_count,
  output int                  pending_count
);
  typedef struct packed {
    logic [8:0]             count;
    logic [StatusWidth-1:0] status;
    logic [KeyWidth-1:0]    max_key;
  } heap_result_t;

  logic signed [KeyWidth-1:0] heap_keys [CAPACITY];
  int unsigned                heap_size;
  logic [ArityWidth-1:0]      arity_reg;
  heap_result_t               awaited_results [$];

  function automatic heap_result_t apply_item(logic op, logic signed [KeyWidth-1:0] key);
    heap_result_t r;
    int unsigned d, pos, up, best, ch;
    logic signed [KeyWidth-1:0] t;
    d = (arity_reg < 2) ? 2 : (arity_reg > MAX_ARITY) ? MAX_ARITY : arity_reg;
    r = '0;
    if (op == OP_INSERT) begin
      if (heap_size >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        pos = heap_size;
        heap_size++;
        while (pos > 0) begin
          up = (pos - 1) / d;
          if (!(heap_keys[up] < key)) break;
          heap_keys[pos] = heap_keys[up];
          pos = up;
        end
        heap_keys[pos] = key;
      end
    end else if (heap_size == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.max_key = heap_keys[0];
      heap_size--;
      if (heap_size > 0) begin
        heap_keys[0] = heap_keys[heap_size];
        pos = 0;
        forever begin
          best = pos;
          for (int c = 0; c < d; c++) begin
            ch = d * pos + 1 + c;
            if (ch >= heap_size) break;
            if (heap_keys[ch] > heap_keys[best]) best = ch;
          end
          if (best == pos) break;
          t = heap_keys[pos];
          heap_keys[pos] = heap_keys[best];
          heap_keys[best] = t;
          pos = best;
        end
      end
    end
    r.count  = heap_size[8:0];
    return r;
  endfunction

  always @(posedge clk) begin
    heap_result_t seen, want;
    if (rst) begin
      heap_size = 0;
      arity_reg = ARITY_RESET;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && paddr == REG_ARITY)
        arity_reg = pwdata[ArityWidth-1:0];
      if (s_tvalid && s_tready)
        awaited_results.push_back(apply_item(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        seen = m_tdata[42:0];
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, seen);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (seen.max_key !== want.max_key) begin
            $display("%0t: max_key expected %h actual %h", $time, want.max_key, seen.max_key);
            fail_count++;
          end
          if (seen.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, seen.status);
            fail_count++;
          end
          if (seen.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, seen.count);
            fail_count++;
          end
        end
      end
    end
    pending_count = awaited_results.size();
  end
endmodule

// ===== dv/d_ary_max_heap_queue_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// d_ary_max_heap_queue_test
// Drives inserts and extracts through the queue under several arities, with
// random gaps and stalls on both streams; a checker predicts every result.
// ----------------------------------------------------------------------------
module d_ary_max_heap_queue_test;
  import dahq_pkg::*;

  logic                clk, rst;
  logic                s_tvalid, s_tready, s_tuser;
  logic [KeyWidth-1:0] s_tdata;
  logic                m_tvalid, m_tready;
  logic [47:0]         m_tdata;
  logic                psel, penable, pwrite, pready;
  logic [1:0]          paddr;
  logic [31:0]         pwdata, prdata;
  int                  fail_count, pending_count;

  // Receiver control: a long hold-off may be requested by the stimulus.
  bit                  hold_results;

  // Entries the heap holds once every item sent so far has been worked on.
  int                  fill_level;

  d_ary_max_heap_queue dut (.*);

  heap_queue_checker check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Runaway guard: far beyond the slowest legal run.
  initial begin
    #60ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: a random stall, often none, before every transfer; a long
  // hold-off asked for by the stimulus comes first and stalls the block.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_results) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_results = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Sends one item and waits for its transfer, after a random gap unless no_gap is set.
  // tvalid stays high after the transfer so that items can follow directly;
  // drain() takes it low.
  task automatic send_item(logic op, logic [KeyWidth-1:0] key, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= key;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (op == OP_INSERT) begin
      if (fill_level < DefCapacity) fill_level++;
    end else if (fill_level > 0) begin
      fill_level--;
    end
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_arity(logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_ARITY; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Waits for every result to come home, then idles the inputs for a margin.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // Empties the heap, ending on an extract from empty, so the arity may be
  // changed safely.
  task automatic empty_heap();
    repeat (fill_level + 1) send_item(OP_EXTRACT, $urandom);
    drain();
  endtask

  function automatic logic [KeyWidth-1:0] random_key();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom_range(0, 15) - 8;   // dense duplicates
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] arities [6];
    arities = '{32'd8, 32'd3, 32'd0, 32'd15, 32'd5, 32'd2};
    s_tvalid = 1'b0; s_tuser = OP_INSERT; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_results = 1'b0;
    fill_level = 0;
    rst = 1'b1;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Directed: extract from empty, key extremes, ties, then draining.
    send_item(OP_EXTRACT, 32'hffff_ffff);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h7fff_ffff);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'h7fff_ffff);
    send_item(OP_INSERT, 32'hffff_ffff);
    send_item(OP_INSERT, 32'h5555_5555);
    send_item(OP_INSERT, 32'haaaa_aaaa);
    repeat (8) send_item(OP_EXTRACT, 32'h0);
    drain();

    // Send more inserts than the capacity, first with the receiver held off so
    // the input stalls; the full-heap case is reached, then the heap is emptied.
    hold_results = 1'b1;
    repeat (260) send_item(OP_INSERT, random_key(), 1);
    drain();
    empty_heap();

    // Random phases: one per arity setting, including the out-of-range ones.
    foreach (arities[p]) begin
      write_arity(arities[p]);
      repeat (55) begin
        send_item(($urandom_range(0, 9) < 6) ? OP_INSERT : OP_EXTRACT, random_key());
      end
      drain();
      empty_heap();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/dahq_pkg.sv
sv/d_ary_max_heap_queue.sv
dv/heap_queue_checker.sv
dv/d_ary_max_heap_queue_test.sv
